// ===== design/flash_record_ring_controller_assert.svh =====
// Assertion macros shared by the ring controller modules.
// Both expect clk and rst in scope.
`ifndef FLASH_RECORD_RING_CONTROLLER_ASSERT_SVH
`define FLASH_RECORD_RING_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define FRC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/frc_pkg.sv =====
`timescale 1ns / 1ps
package frc_pkg;

  localparam int unsigned MAX_SLOTS      = 4096;
  localparam int unsigned MAX_HEAD_SLOTS = 4096;
  localparam int unsigned HEAD_BYTES     = 16;
  localparam int unsigned CHECKSUM_BYTES = 4;

  // operations
  localparam logic [2:0] OP_PUSH        = 3'd0;
  localparam logic [2:0] OP_READ_POS    = 3'd1;
  localparam logic [2:0] OP_READ_NEWEST = 3'd2;
  localparam logic [2:0] OP_CLEAR       = 3'd3;
  localparam logic [2:0] OP_RESTORE     = 3'd4;

  // memory commands
  localparam logic [2:0] CMD_STATUS     = 3'd0;
  localparam logic [2:0] CMD_ERASE      = 3'd1;
  localparam logic [2:0] CMD_FILL       = 3'd2;
  localparam logic [2:0] CMD_WRITE_REC  = 3'd3;
  localparam logic [2:0] CMD_WRITE_HEAD = 3'd4;
  localparam logic [2:0] CMD_READ_REC   = 3'd5;

  // status codes
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_RECORD_BASE = 3'd0;
  localparam logic [2:0] CFG_HEAD_BASE   = 3'd1;
  localparam logic [2:0] CFG_RECORD_BYTES = 3'd2;
  localparam logic [2:0] CFG_UNIT_BYTES  = 3'd3;
  localparam logic [2:0] CFG_RECORD_SLOTS = 3'd4;
  localparam logic [2:0] CFG_HEAD_SLOTS  = 3'd5;
  localparam logic [2:0] CFG_ERASE       = 3'd6;
  localparam logic [2:0] CFG_CHECKSUM    = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RPU,
    S_RPU_WAIT,
    S_UM,
    S_DECODE,
    S_J_ADDR,
    S_J_DIVW,
    S_J_MUL1,
    S_J_MUL2,
    S_J_CHK,
    S_J_FDIVW,
    S_J_FMUL,
    S_J_EMIT,
    S_STAT
  } state_t;

  typedef enum logic [1:0] {
    JK_REC,
    JK_HEAD,
    JK_RAW
  } job_kind_t;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_REM0,
    JC_FLOOR_A,
    JC_FLOOR_B
  } job_cond_t;

  typedef struct packed {
    job_kind_t   kind;
    job_cond_t   cond;
    logic [2:0]  cmd;
    logic [12:0] idx;
    logic [12:0] len;
    logic [12:0] hc;
    logic [11:0] hi;
    logic [31:0] hs;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/frc_div.sv =====
`timescale 1ns / 1ps
`include "flash_record_ring_controller_assert.svh"
module frc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [16:0]         divisor,
  output frc_pkg::div_stat_t  stat,
  output logic [31:0]         quotient,
  output logic [16:0]         remainder
);

  localparam int STEPS = 32;

  logic        busy;
  logic        done;
  logic [4:0]  count;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [16:0] dvs;
  logic [17:0] shifted;
  logic [17:0] diff;
  logic        ge;

  // restoring divider, one quotient bit per cycle
  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[16:0] : shifted[16:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

  `FRC_ASSERT(div_start_idle, start, !busy, "divider started while busy")
  `FRC_ASSERT(div_rem_range, done && dvs != '0, rem < dvs, "remainder not below divisor")
  `FRC_ASSERT_NEXT(div_done_pulse, done, !done && !busy, "done held or busy after done")

endmodule

// ===== design/flash_record_ring_controller.sv =====
`timescale 1ns / 1ps
`include "flash_record_ring_controller_assert.svh"
// Ring-of-records pointer keeper for non-volatile memory.
// Input channel (in_valid/in_ready) takes one operation word: push, read at
// position, read newest, clear or restore. For each operation the block sends
// zero to four memory command words on the output channel (out_valid/
// out_ready) followed by one status word with last=1.
// Operations run one at a time; in_ready is high only while the sequencer is
// idle. All slot/unit divisions go through one shared 32-step restoring
// divider: each operation first divides the unit size by the record size
// (skipped when the record size is zero or exceeds the unit), each command
// address with erase packing divides the slot index by the slots per unit,
// and a unit-aligned address during clear adds a divide by the unit size.
// Configuration writes (cfg_write/cfg_index/cfg_data) are taken any cycle and
// must only happen while idle.
// A stalled receiver holds the output register; the sequencer waits on it
// and loses nothing. An operation may be accepted while the previous status
// word still waits. Reset (rst, synchronous) restores register defaults and
// an empty ring: no newest slot, zero count, head slot 0, sequence 0.
module flash_record_ring_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [11:0]        record_position,
  input  logic signed [12:0] restore_last_index,
  input  logic [12:0]        restore_count,
  input  logic [11:0]        restore_head_next,
  input  logic [31:0]        restore_sequence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         command,
  output logic [31:0]        address,
  output logic [12:0]        length,
  output logic [12:0]        head_record_count,
  output logic [11:0]        head_record_index,
  output logic [31:0]        head_sequence,
  output logic [1:0]         status,
  output logic [12:0]        stored_count,
  output logic               last
);

  // configuration
  logic [31:0] rab, hab;
  logic [12:0] rb, rs, hs;
  logic [16:0] eub;
  logic        ebw, chk;

  // ring state
  logic signed [12:0] newest_slot;
  logic [12:0]        held_count;
  logic [11:0]        next_head_slot;
  logic [31:0]        write_sequence;

  // latched operation
  logic [2:0]         op;
  logic [11:0]        pos;
  logic signed [12:0] r_last;
  logic [12:0]        r_cnt;
  logic [11:0]        r_hn;
  logic [31:0]        r_seq;

  frc_pkg::state_t state, state_next;

  // per-operation work registers
  logic [16:0]  rpu;
  logic [12:0]  um;
  frc_pkg::job_t jobs [4];
  logic [2:0]   njob;
  logic [1:0]   jptr;
  logic [31:0]  acc, fl, al;
  logic [12:0]  q13;
  logic [31:0]  q32;
  logic [16:0]  rm;
  logic         remz;
  logic [1:0]   st;

  // divider
  logic               div_start;
  logic [31:0]        div_dividend;
  logic [16:0]        div_divisor;
  frc_pkg::div_stat_t div_st;
  logic [31:0]        div_q;
  logic [16:0]        div_r;

  frc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_st),
    .quotient (div_q),
    .remainder(div_r)
  );

  // derived configuration
  logic [12:0] slots, heads, dl;
  logic [16:0] hpu;

  always_comb begin
    if (rs < 13'd3) slots = 13'd3;
    else if (rs > 13'(frc_pkg::MAX_SLOTS)) slots = 13'(frc_pkg::MAX_SLOTS);
    else slots = rs;
    if (hs > 13'(frc_pkg::MAX_HEAD_SLOTS)) heads = 13'(frc_pkg::MAX_HEAD_SLOTS);
    else heads = hs;
    hpu = (eub < 17'(frc_pkg::HEAD_BYTES)) ? 17'd1 : (eub >> 4);
    if (chk) dl = (rb >= 13'(frc_pkg::CHECKSUM_BYTES)) ?
                  rb - 13'(frc_pkg::CHECKSUM_BYTES) : 13'd0;
    else dl = rb;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rab <= '0;
      hab <= '0;
      rb  <= 13'd64;
      eub <= 17'd4096;
      rs  <= 13'd64;
      hs  <= '0;
      ebw <= 1'b0;
      chk <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        frc_pkg::CFG_RECORD_BASE:  rab <= cfg_data;
        frc_pkg::CFG_HEAD_BASE:    hab <= cfg_data;
        frc_pkg::CFG_RECORD_BYTES: rb  <= cfg_data[12:0];
        frc_pkg::CFG_UNIT_BYTES:   eub <= cfg_data[16:0];
        frc_pkg::CFG_RECORD_SLOTS: rs  <= cfg_data[12:0];
        frc_pkg::CFG_HEAD_SLOTS:   hs  <= cfg_data[12:0];
        frc_pkg::CFG_ERASE:        ebw <= cfg_data[0];
        frc_pkg::CFG_CHECKSUM:     chk <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic frc_pkg::job_t mk_job(frc_pkg::job_kind_t kind,
                                            frc_pkg::job_cond_t cond,
                                            logic [2:0] cmd, logic [12:0] idx,
                                            logic [12:0] len, logic [12:0] hc,
                                            logic [11:0] hi, logic [31:0] hs_v);
    frc_pkg::job_t j;
    j.kind = kind;
    j.cond = cond;
    j.cmd  = cmd;
    j.idx  = idx;
    j.len  = len;
    j.hc   = hc;
    j.hi   = hi;
    j.hs   = hs_v;
    return j;
  endfunction

  // operation decode: job list and new ring state
  logic signed [13:0] nx_s, slots_s;
  logic [12:0]        nx, nn, nh, cnt_new, pos_eff, rd_idx;
  logic [13:0]        nn_w, nh_w;
  logic signed [14:0] real_s, real_w;
  logic               rd_ok, rst_bad;
  frc_pkg::job_t      dj [4];
  logic [2:0]         dn;
  logic signed [12:0] d_newest;
  logic [12:0]        d_held;
  logic [11:0]        d_nhs;
  logic [31:0]        d_seq;
  logic [1:0]         d_st;

  always_comb begin
    slots_s = $signed({1'b0, slots});
    nx_s    = 14'(newest_slot) + 14'sd1;
    nx      = (nx_s >= slots_s || nx_s < 0) ? 13'd0 : nx_s[12:0];
    nn_w    = {1'b0, nx} + 14'd1;
    nn      = (nn_w >= {1'b0, slots}) ? 13'd0 : nn_w[12:0];
    nh_w    = {2'b0, next_head_slot} + 14'd1;
    nh      = (nh_w >= {1'b0, heads}) ? 13'd0 : nh_w[12:0];
    cnt_new = (held_count < um) ? held_count + 13'd1 : held_count;

    pos_eff = (op == frc_pkg::OP_READ_NEWEST) ? held_count - 13'd1 : {1'b0, pos};
    rd_ok   = (held_count != '0) && (pos_eff < held_count);
    real_s  = 15'(newest_slot) + 15'sd1 - $signed({2'b0, held_count})
              + $signed({2'b0, pos_eff});
    real_w  = (real_s < 0) ? real_s + $signed({2'b0, slots}) : real_s;
    rd_idx  = (real_w < 0) ? 13'd0 : real_w[12:0];

    rst_bad = !(r_last == -13'sd1 && r_cnt == '0) &&
              (r_last < 0 || 14'(r_last) >= slots_s || r_cnt > um);

    for (int k = 0; k < 4; k++) dj[k] = '0;
    dn       = '0;
    d_newest = newest_slot;
    d_held   = held_count;
    d_nhs    = next_head_slot;
    d_seq    = write_sequence;
    d_st     = frc_pkg::ST_SUCCESS;

    case (op)
      frc_pkg::OP_PUSH: begin
        if (heads == '0) begin
          if (ebw) dj[dn[1:0]] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_REM0,
                                        frc_pkg::CMD_ERASE, nn, '0, '0, '0, '0);
          else dj[dn[1:0]] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_ALWAYS,
                                    frc_pkg::CMD_FILL, nn, rb, '0, '0, '0);
          dn = dn + 3'd1;
        end else if (ebw) begin
          dj[dn[1:0]] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_REM0,
                               frc_pkg::CMD_ERASE, nx, '0, '0, '0, '0);
          dn = dn + 3'd1;
        end
        dj[dn[1:0]] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_ALWAYS,
                             frc_pkg::CMD_WRITE_REC, nx, dl, '0, '0, '0);
        dn = dn + 3'd1;
        if (heads != '0) begin
          if (ebw) dj[dn[1:0]] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_REM0,
                                        frc_pkg::CMD_ERASE, nh, '0, '0, '0, '0);
          else dj[dn[1:0]] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_ALWAYS,
                                    frc_pkg::CMD_FILL, nh,
                                    13'(frc_pkg::HEAD_BYTES), '0, '0, '0);
          dn = dn + 3'd1;
          dj[dn[1:0]] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_ALWAYS,
                               frc_pkg::CMD_WRITE_HEAD, {1'b0, next_head_slot},
                               13'(frc_pkg::HEAD_BYTES - frc_pkg::CHECKSUM_BYTES),
                               cnt_new, nx[11:0], write_sequence + 32'd1);
          dn = dn + 3'd1;
          d_nhs = nh[11:0];
        end
        d_newest = $signed(nx);
        d_held   = cnt_new;
        d_seq    = write_sequence + 32'd1;
      end
      frc_pkg::OP_READ_POS, frc_pkg::OP_READ_NEWEST: begin
        if (op == frc_pkg::OP_READ_NEWEST && held_count == '0) begin
          d_st = frc_pkg::ST_EMPTY;
        end else if (!rd_ok) begin
          d_st = frc_pkg::ST_BAD_POS;
        end else begin
          dj[0] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_ALWAYS,
                         frc_pkg::CMD_READ_REC, rd_idx, dl, '0, '0, '0);
          dn = 3'd1;
        end
      end
      frc_pkg::OP_CLEAR: begin
        if (held_count != '0) begin
          if (heads != '0) begin
            if (ebw) dj[0] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_REM0,
                                    frc_pkg::CMD_ERASE, nh, '0, '0, '0, '0);
            else dj[0] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_ALWAYS,
                                frc_pkg::CMD_FILL, nh,
                                13'(frc_pkg::HEAD_BYTES), '0, '0, '0);
            dj[1] = mk_job(frc_pkg::JK_HEAD, frc_pkg::JC_ALWAYS,
                           frc_pkg::CMD_WRITE_HEAD, {1'b0, next_head_slot},
                           13'(frc_pkg::HEAD_BYTES - frc_pkg::CHECKSUM_BYTES),
                           '0, newest_slot[11:0], write_sequence + 32'd1);
            dn    = 3'd2;
            d_nhs = nh[11:0];
          end else if (ebw) begin
            // erase first unit and the units holding the last two slots
            dj[0] = mk_job(frc_pkg::JK_RAW, frc_pkg::JC_ALWAYS,
                           frc_pkg::CMD_ERASE, '0, '0, '0, '0, '0);
            dj[1] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_FLOOR_A,
                           frc_pkg::CMD_ERASE, slots - 13'd1, '0, '0, '0, '0);
            dj[2] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_FLOOR_B,
                           frc_pkg::CMD_ERASE, slots - 13'd2, '0, '0, '0, '0);
            dn       = 3'd3;
            d_newest = -13'sd1;
          end else begin
            dj[0] = mk_job(frc_pkg::JK_RAW, frc_pkg::JC_ALWAYS,
                           frc_pkg::CMD_FILL, '0, rb, '0, '0, '0);
            dj[1] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_ALWAYS,
                           frc_pkg::CMD_FILL, slots - 13'd1, rb, '0, '0, '0);
            dj[2] = mk_job(frc_pkg::JK_REC, frc_pkg::JC_ALWAYS,
                           frc_pkg::CMD_FILL, slots - 13'd2, rb, '0, '0, '0);
            dn       = 3'd3;
            d_newest = -13'sd1;
          end
          d_held = '0;
          d_seq  = write_sequence + 32'd1;
        end
      end
      frc_pkg::OP_RESTORE: begin
        d_newest = rst_bad ? -13'sd1 : r_last;
        d_held   = rst_bad ? 13'd0 : r_cnt;
        d_nhs    = ({1'b0, r_hn} >= heads) ? 12'd0 : r_hn;
        d_seq    = r_seq;
      end
      default: ;
    endcase
  end

  // current job
  frc_pkg::job_t cj;
  logic [31:0]   jbase;
  logic [12:0]   jstride;
  logic          out_free;
  logic          emit_en;
  logic [31:0]   emit_addr;
  logic          load_job, load_stat;
  logic signed [18:0] um_w;

  assign cj       = jobs[jptr];
  assign jbase    = (cj.kind == frc_pkg::JK_HEAD) ? hab : rab;
  assign jstride  = (cj.kind == frc_pkg::JK_HEAD) ? 13'(frc_pkg::HEAD_BYTES) : rb;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == frc_pkg::S_IDLE);

  always_comb begin
    um_w = $signed({6'b0, slots});
    if (ebw) um_w = um_w - $signed({2'b0, rpu});
    if (heads == '0) um_w = um_w - (ebw ? 19'sd1 : 19'sd2);
  end

  always_comb begin
    case (cj.cond)
      frc_pkg::JC_REM0:    begin emit_en = remz; emit_addr = acc; end
      frc_pkg::JC_FLOOR_A: begin emit_en = (fl != rab); emit_addr = fl; end
      frc_pkg::JC_FLOOR_B: begin emit_en = (fl != al) && (fl != rab); emit_addr = fl; end
      default:             begin emit_en = 1'b1; emit_addr = acc; end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= frc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = {19'b0, cj.idx};
    div_divisor  = (cj.kind == frc_pkg::JK_HEAD) ? hpu : rpu;
    load_job     = 1'b0;
    load_stat    = 1'b0;
    unique case (state)
      frc_pkg::S_IDLE: if (in_valid) state_next = frc_pkg::S_RPU;
      frc_pkg::S_RPU: begin
        if (rb == '0 || {4'b0, rb} > eub) begin
          state_next = frc_pkg::S_UM;
        end else begin
          div_start    = 1'b1;
          div_dividend = {15'b0, eub};
          div_divisor  = {4'b0, rb};
          state_next   = frc_pkg::S_RPU_WAIT;
        end
      end
      frc_pkg::S_RPU_WAIT: if (div_st.done) state_next = frc_pkg::S_UM;
      frc_pkg::S_UM:     state_next = frc_pkg::S_DECODE;
      frc_pkg::S_DECODE: state_next = (dn == '0) ? frc_pkg::S_STAT : frc_pkg::S_J_ADDR;
      frc_pkg::S_J_ADDR: begin
        if (cj.kind == frc_pkg::JK_RAW || !ebw) begin
          state_next = frc_pkg::S_J_CHK;
        end else begin
          div_start  = 1'b1;
          state_next = frc_pkg::S_J_DIVW;
        end
      end
      frc_pkg::S_J_DIVW: if (div_st.done) state_next = frc_pkg::S_J_MUL1;
      frc_pkg::S_J_MUL1: state_next = frc_pkg::S_J_MUL2;
      frc_pkg::S_J_MUL2: state_next = frc_pkg::S_J_CHK;
      frc_pkg::S_J_CHK: begin
        if ((cj.cond == frc_pkg::JC_FLOOR_A || cj.cond == frc_pkg::JC_FLOOR_B)
            && eub != '0) begin
          div_start    = 1'b1;
          div_dividend = acc;
          div_divisor  = eub;
          state_next   = frc_pkg::S_J_FDIVW;
        end else begin
          state_next = frc_pkg::S_J_EMIT;
        end
      end
      frc_pkg::S_J_FDIVW: if (div_st.done) state_next = frc_pkg::S_J_FMUL;
      frc_pkg::S_J_FMUL:  state_next = frc_pkg::S_J_EMIT;
      frc_pkg::S_J_EMIT: begin
        if (out_free) begin
          load_job   = emit_en;
          state_next = ({1'b0, jptr} == njob - 3'd1) ? frc_pkg::S_STAT
                                                      : frc_pkg::S_J_ADDR;
        end
      end
      frc_pkg::S_STAT: begin
        if (out_free) begin
          load_stat  = 1'b1;
          state_next = frc_pkg::S_IDLE;
        end
      end
      default: state_next = frc_pkg::S_IDLE;
    endcase
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot    <= -13'sd1;
      held_count     <= '0;
      next_head_slot <= '0;
      write_sequence <= '0;
    end else if (state == frc_pkg::S_DECODE) begin
      newest_slot    <= d_newest;
      held_count     <= d_held;
      next_head_slot <= d_nhs;
      write_sequence <= d_seq;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      frc_pkg::S_IDLE: begin
        op     <= operation;
        pos    <= record_position;
        r_last <= restore_last_index;
        r_cnt  <= restore_count;
        r_hn   <= restore_head_next;
        r_seq  <= restore_sequence;
        rpu    <= 17'd1;
      end
      frc_pkg::S_RPU_WAIT: if (div_st.done) rpu <= div_q[16:0];
      frc_pkg::S_UM: um <= (um_w < 0) ? 13'd0 : um_w[12:0];
      frc_pkg::S_DECODE: begin
        for (int k = 0; k < 4; k++) jobs[k] <= dj[k];
        njob <= dn;
        jptr <= '0;
        st   <= d_st;
      end
      frc_pkg::S_J_ADDR: begin
        remz <= 1'b1;
        if (cj.kind == frc_pkg::JK_RAW) acc <= rab;
        else acc <= jbase + 32'(cj.idx) * 32'(jstride);
      end
      frc_pkg::S_J_DIVW: if (div_st.done) begin
        q13 <= div_q[12:0];
        rm  <= div_r;
      end
      frc_pkg::S_J_MUL1: begin
        acc  <= jbase + 32'(q13) * 32'(eub);
        remz <= (rm == '0);
      end
      frc_pkg::S_J_MUL2: acc <= acc + 32'(rm) * 32'(jstride);
      frc_pkg::S_J_CHK: fl <= acc;
      frc_pkg::S_J_FDIVW: if (div_st.done) q32 <= div_q;
      frc_pkg::S_J_FMUL: fl <= q32 * 32'(eub);
      frc_pkg::S_J_EMIT: if (out_free) begin
        if (cj.cond == frc_pkg::JC_FLOOR_A) al <= fl;
        jptr <= jptr + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_job || load_stat) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      command           <= cj.cmd;
      address           <= emit_addr;
      length            <= cj.len;
      head_record_count <= cj.hc;
      head_record_index <= cj.hi;
      head_sequence     <= cj.hs;
      status            <= frc_pkg::ST_SUCCESS;
      stored_count      <= '0;
      last              <= 1'b0;
    end else if (load_stat) begin
      command           <= frc_pkg::CMD_STATUS;
      address           <= '0;
      length            <= '0;
      head_record_count <= '0;
      head_record_index <= '0;
      head_sequence     <= '0;
      status            <= st;
      stored_count      <= held_count;
      last              <= 1'b1;
    end
  end

  `FRC_ASSERT_NEXT(seq_leaves_idle, in_valid && in_ready, !in_ready, "sequencer stayed idle")
  `FRC_ASSERT(stat_is_last, out_valid && last, command == frc_pkg::CMD_STATUS,
              "last word is not a status word")
  `FRC_ASSERT(idle_div_quiet, in_ready, !div_st.busy, "divider busy while idle")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int STALL_MAX  = 10;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_WAIT  = 250;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [12:0] len;
    logic [12:0] hc;
    logic [11:0] hi;
    logic [31:0] hs;
    logic [1:0]  st;
    logic [12:0] sc;
    logic        lst;
  } mem_cmd_t;

  logic clk, rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] operation;
  logic [11:0] record_position;
  logic signed [12:0] restore_last_index;
  logic [12:0] restore_count;
  logic [11:0] restore_head_next;
  logic [31:0] restore_sequence;
  logic out_valid, out_ready;
  logic [2:0] command;
  logic [31:0] address;
  logic [12:0] length, head_record_count, stored_count;
  logic [11:0] head_record_index;
  logic [31:0] head_sequence;
  logic [1:0] status;
  logic last;

  flash_record_ring_controller u_dut (.*);

  // shadow registers
  logic [31:0] r_rec_base, r_head_base;
  logic [12:0] r_rec_bytes, r_rec_slots, r_head_slots;
  logic [16:0] r_unit_bytes;
  logic r_erase, r_chk;
  // shadow ring pointers
  int newest, held;
  int unsigned head_next;
  logic [31:0] seq_num;

  mem_cmd_t pending_cmds[$];
  int mismatches;
  int idle_cycles;
  bit fast_in, fast_out;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int ring_slots();
    int s = r_rec_slots;
    if (s < 3) s = 3;
    if (s > 4096) s = 4096;
    return s;
  endfunction

  function automatic int unsigned ring_heads();
    return (r_head_slots > 4096) ? 4096 : r_head_slots;
  endfunction

  function automatic int unsigned recs_per_unit();
    if (r_rec_bytes == 0 || r_rec_bytes > r_unit_bytes) return 1;
    return r_unit_bytes / r_rec_bytes;
  endfunction

  function automatic int unsigned heads_per_unit();
    if (r_unit_bytes < frc_pkg::HEAD_BYTES) return 1;
    return r_unit_bytes / frc_pkg::HEAD_BYTES;
  endfunction

  function automatic int usable_max();
    int u = ring_slots();
    if (r_erase) begin
      u -= recs_per_unit();
      if (ring_heads() == 0) u -= 1;
    end else if (ring_heads() == 0) begin
      u -= 2;
    end
    return u < 0 ? 0 : u;
  endfunction

  function automatic logic [31:0] slot_addr(int unsigned i);
    logic [31:0] r, q, m;
    if (r_erase) begin
      r = recs_per_unit();
      q = i / r;
      m = i % r;
      return r_rec_base + q * r_unit_bytes + m * r_rec_bytes;
    end
    return r_rec_base + i * r_rec_bytes;
  endfunction

  function automatic logic [31:0] head_addr(int unsigned i);
    logic [31:0] h, q, m;
    if (r_erase) begin
      h = heads_per_unit();
      q = i / h;
      m = i % h;
      return r_head_base + q * r_unit_bytes + m * frc_pkg::HEAD_BYTES;
    end
    return r_head_base + i * frc_pkg::HEAD_BYTES;
  endfunction

  function automatic logic [31:0] unit_floor(logic [31:0] a);
    logic [31:0] u = r_unit_bytes;
    if (u == 0) return a;
    return (a / u) * u;
  endfunction

  function automatic logic [12:0] data_len();
    if (r_chk) return (r_rec_bytes >= 13'(frc_pkg::CHECKSUM_BYTES)) ?
                      r_rec_bytes - 13'(frc_pkg::CHECKSUM_BYTES) : 13'd0;
    return r_rec_bytes;
  endfunction

  function automatic void add_cmd(logic [2:0] c, logic [31:0] a, logic [12:0] l,
                                  logic [12:0] hc = 0, logic [11:0] hi = 0,
                                  logic [31:0] hs = 0, logic [1:0] st = 0,
                                  logic [12:0] sc = 0, logic lst = 0);
    mem_cmd_t e;
    e = '{c, a, l, hc, hi, hs, st, sc, lst};
    pending_cmds.push_back(e);
  endfunction

  function automatic void head_update(int unsigned cnt, int unsigned idx, logic [31:0] s);
    int unsigned nn = head_next + 1;
    if (nn >= ring_heads()) nn = 0;
    if (r_erase) begin
      if (nn % heads_per_unit() == 0) add_cmd(frc_pkg::CMD_ERASE, head_addr(nn), 0);
    end else begin
      add_cmd(frc_pkg::CMD_FILL, head_addr(nn), 13'(frc_pkg::HEAD_BYTES));
    end
    add_cmd(frc_pkg::CMD_WRITE_HEAD, head_addr(head_next),
            13'(frc_pkg::HEAD_BYTES - frc_pkg::CHECKSUM_BYTES),
            cnt[12:0], idx[11:0], s);
    head_next = nn;
  endfunction

  function automatic logic [1:0] read_slot(int pos);
    int real_slot;
    if (held <= 0 || pos >= held || pos < 0) return frc_pkg::ST_BAD_POS;
    real_slot = newest + 1 - held + pos;
    if (real_slot < 0) real_slot += ring_slots();
    if (real_slot < 0) real_slot = 0;
    add_cmd(frc_pkg::CMD_READ_REC, slot_addr(real_slot), data_len());
    return frc_pkg::ST_SUCCESS;
  endfunction

  function automatic void predict_cmds(logic [2:0] op, logic [11:0] pos, logic [12:0] rl,
                                       logic [12:0] rc, logic [11:0] rh, logic [31:0] rs);
    int slots = ring_slots();
    int nx, nn, cnt, lst_slot;
    logic [31:0] al, apl;
    logic [1:0] st = frc_pkg::ST_SUCCESS;
    case (op)
      frc_pkg::OP_PUSH: begin
        nx = newest + 1;
        if (nx >= slots || nx < 0) nx = 0;
        nn = nx + 1;
        if (nn >= slots) nn = 0;
        if (ring_heads() == 0) begin
          if (r_erase) begin
            if (nn % recs_per_unit() == 0) add_cmd(frc_pkg::CMD_ERASE, slot_addr(nn), 0);
          end else begin
            add_cmd(frc_pkg::CMD_FILL, slot_addr(nn), r_rec_bytes);
          end
        end else if (r_erase) begin
          if (nx % recs_per_unit() == 0) add_cmd(frc_pkg::CMD_ERASE, slot_addr(nx), 0);
        end
        add_cmd(frc_pkg::CMD_WRITE_REC, slot_addr(nx), data_len());
        cnt = held;
        if (cnt < usable_max()) cnt++;
        if (ring_heads() > 0) head_update(cnt, nx, seq_num + 32'd1);
        newest = nx;
        held = cnt;
        seq_num++;
      end
      frc_pkg::OP_READ_POS: st = read_slot(pos);
      frc_pkg::OP_READ_NEWEST: st = (held <= 0) ? frc_pkg::ST_EMPTY : read_slot(held - 1);
      frc_pkg::OP_CLEAR: begin
        if (held > 0) begin
          if (ring_heads() > 0) begin
            head_update(0, newest, seq_num + 32'd1);
          end else begin
            if (r_erase) begin
              al = unit_floor(slot_addr(slots - 1));
              apl = unit_floor(slot_addr(slots - 2));
              add_cmd(frc_pkg::CMD_ERASE, r_rec_base, 0);
              if (al != r_rec_base) add_cmd(frc_pkg::CMD_ERASE, al, 0);
              if (apl != al && apl != r_rec_base) add_cmd(frc_pkg::CMD_ERASE, apl, 0);
            end else begin
              add_cmd(frc_pkg::CMD_FILL, r_rec_base, r_rec_bytes);
              add_cmd(frc_pkg::CMD_FILL, slot_addr(slots - 1), r_rec_bytes);
              add_cmd(frc_pkg::CMD_FILL, slot_addr(slots - 2), r_rec_bytes);
            end
            newest = -1;
          end
          held = 0;
          seq_num++;
        end
      end
      frc_pkg::OP_RESTORE: begin
        lst_slot = $signed(rl);
        cnt = rc;
        if (!(lst_slot == -1 && cnt == 0) &&
            (lst_slot < 0 || lst_slot >= slots || cnt > usable_max())) begin
          lst_slot = -1;
          cnt = 0;
        end
        newest = lst_slot;
        held = cnt;
        head_next = (rh >= ring_heads()) ? 0 : rh;
        seq_num = rs;
      end
      default: ;
    endcase
    add_cmd(frc_pkg::CMD_STATUS, 0, 0, 0, 0, 0, st, held[12:0], 1'b1);
  endfunction

  // caller sits at a falling edge; valid stays high after acceptance
  task automatic send_op(logic [2:0] op, logic [11:0] pos = 0, logic [12:0] rl = 0,
                         logic [12:0] rc = 0, logic [11:0] rh = 0, logic [31:0] rs = 0);
    int gap = fast_in ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    record_position <= pos;
    restore_last_index <= rl;
    restore_count <= rc;
    restore_head_next <= rh;
    restore_sequence <= rs;
    do @(posedge clk); while (!in_ready);
    predict_cmds(op, pos, rl, rc, rh, rs);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_cmds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(logic [31:0] rbase, logic [31:0] hbase, logic [12:0] rb,
                            logic [16:0] ub, logic [12:0] rsl, logic [12:0] hsl,
                            logic er, logic ck);
    logic [31:0] vals[8];
    drain();
    vals = '{rbase, hbase, rb, ub, rsl, hsl, er, ck};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    r_rec_base = rbase;
    r_head_base = hbase;
    r_rec_bytes = rb;
    r_unit_bytes = ub;
    r_rec_slots = rsl;
    r_head_slots = hsl;
    r_erase = er;
    r_chk = ck;
    @(negedge clk);
  endtask

  task automatic random_ops(int n);
    int sel;
    logic [11:0] pos;
    for (int k = 0; k < n; k++) begin
      if (k % 12 == 0) fast_in = ($urandom_range(0, 3) == 0);
      if (k == n / 2) drain();
      sel = $urandom_range(0, 99);
      if (sel < 35) send_op(frc_pkg::OP_PUSH);
      else if (sel < 55) begin
        if (held > 0 && $urandom_range(0, 4) != 0) pos = 12'($urandom_range(0, held - 1));
        else pos = 12'($urandom_range(0, 4095));
        send_op(frc_pkg::OP_READ_POS, pos);
      end
      else if (sel < 70) send_op(frc_pkg::OP_READ_NEWEST);
      else if (sel < 78) send_op(frc_pkg::OP_CLEAR);
      else if (sel < 95) begin
        if ($urandom_range(0, 3) != 0)
          send_op(frc_pkg::OP_RESTORE, 12'($urandom),
                  13'($urandom_range(0, ring_slots() - 1)),
                  13'($urandom_range(0, usable_max())),
                  12'($urandom_range(0, ring_heads() + 1)), $urandom);
        else
          send_op(frc_pkg::OP_RESTORE, 12'($urandom), 13'($urandom), 13'($urandom),
                  12'($urandom), 32'hFFFF_FFFF - $urandom_range(0, 2));
      end
      else send_op(3'($urandom_range(5, 7)), 12'($urandom), 13'($urandom), 13'($urandom),
                   12'($urandom), $urandom);
    end
    fast_in = 0;
  endtask

  task automatic test_reset_defaults();
    send_op(frc_pkg::OP_READ_NEWEST);
    send_op(frc_pkg::OP_READ_POS, 0);
    send_op(frc_pkg::OP_CLEAR);
    send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_READ_POS, 0);
    send_op(frc_pkg::OP_READ_POS, 1);
    send_op(frc_pkg::OP_READ_POS, 12'hFFF);
    send_op(frc_pkg::OP_READ_NEWEST);
    send_op(frc_pkg::OP_CLEAR);
    send_op(frc_pkg::OP_READ_NEWEST);
    send_op(3'd5);
    send_op(3'd6);
    send_op(3'd7);
    send_op(frc_pkg::OP_RESTORE, 0, 13'h1FFF, 0, 0, 32'hFFFF_FFFF);
    send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_RESTORE, 0, 13'd4095, 13'd4096, 12'hFFF, 0);
    send_op(frc_pkg::OP_RESTORE, 0, 13'h1FFE, 13'd1, 0, 0);
    send_op(frc_pkg::OP_RESTORE, 0, 13'd10, 13'd5, 0, 32'hFFFF_FFFE);
    send_op(frc_pkg::OP_READ_POS, 4);
    send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_PUSH);
  endtask

  task automatic test_packed_heads();
    write_regs(32'h1000, 32'h8000, 13'd16, 17'd64, 13'd10, 13'd5, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++) send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_CLEAR);
    random_ops(30);
  endtask

  task automatic test_tiny_ring();
    write_regs(32'hFFFF_FFF0, 32'h0, 13'd1, 17'd16, 13'd3, 13'd0, 1'b0, 1'b0);
    random_ops(30);
  endtask

  task automatic test_extremes();
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd4096, 17'd65536, 13'd4096, 13'd4096,
               1'b1, 1'b1);
    send_op(frc_pkg::OP_RESTORE, 0, 13'd4095, 13'd4000, 12'd4095, 32'hFFFF_FFFF);
    send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_READ_POS, 12'd3999);
    random_ops(20);
  endtask

  task automatic test_degenerate();
    // zero record size, zero erase unit, checksum longer than record
    write_regs(32'h100, 32'h200, 13'd0, 17'd0, 13'd0, 13'h1FFF, 1'b1, 1'b1);
    random_ops(15);
    write_regs(32'h300, 32'h0, 13'd3, 17'd0, 13'd7, 13'd0, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++) send_op(frc_pkg::OP_PUSH);
    send_op(frc_pkg::OP_CLEAR);
    random_ops(15);
  endtask

  task automatic test_random_configs();
    for (int c = 0; c < 3; c++) begin
      write_regs($urandom, $urandom, 13'($urandom_range(1, 200)),
                 17'((16 << $urandom_range(0, 7)) + $urandom_range(0, 15)),
                 13'($urandom_range(3, 40)), 13'($urandom_range(0, 8)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      random_ops(25);
    end
  endtask

  // result receiver: ready pattern
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int stall;
      stall = fast_out ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    forever begin
      fast_out = ($urandom_range(0, 4) == 0);
      repeat (300) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    mem_cmd_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{command, address, length, head_record_count, head_record_index,
              head_sequence, status, stored_count, last};
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_cmds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    fast_in = 0;
    rst = 1'b1;
    cfg_write = 0;
    cfg_index = frc_pkg::CFG_RECORD_BASE;
    cfg_data = 0;
    in_valid = 0;
    operation = frc_pkg::OP_PUSH;
    record_position = 0;
    restore_last_index = 0;
    restore_count = 0;
    restore_head_next = 0;
    restore_sequence = 0;
    r_rec_base = 0;
    r_head_base = 0;
    r_rec_bytes = 64;
    r_unit_bytes = 4096;
    r_rec_slots = 64;
    r_head_slots = 0;
    r_erase = 0;
    r_chk = 0;
    newest = -1;
    held = 0;
    head_next = 0;
    seq_num = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_packed_heads();
    test_tiny_ring();
    test_extremes();
    test_degenerate();
    test_random_configs();
    drain();
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
